### rtl/fbpal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Display register block package
// Shared types, register offsets, request codes and palette geometry.
// ----------------------------------------------------------------------------
package fbpal_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

   // Request codes
   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   // Access size codes (anything else is a long access)
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   // Configuration register indexes
   localparam logic [2:0] CSR_DEVICE_BASE = 3'd0;
   localparam logic [2:0] CSR_MAGIC_ID    = 3'd1;
   localparam logic [2:0] CSR_WIDTH       = 3'd2;
   localparam logic [2:0] CSR_HEIGHT      = 3'd3;
   localparam logic [2:0] CSR_BPP         = 3'd4;
   localparam logic [2:0] CSR_VRAM_BASE   = 3'd5;

   // Register map offsets
   localparam logic [31:0] OFF_MAGIC_0   = 32'h00;
   localparam logic [31:0] OFF_MAGIC_1   = 32'h01;
   localparam logic [31:0] OFF_MAGIC_2   = 32'h02;
   localparam logic [31:0] OFF_MAGIC_3   = 32'h03;
   localparam logic [31:0] OFF_WIDTH_HI  = 32'h04;
   localparam logic [31:0] OFF_WIDTH_LO  = 32'h05;
   localparam logic [31:0] OFF_HEIGHT_HI = 32'h06;
   localparam logic [31:0] OFF_HEIGHT_LO = 32'h07;
   localparam logic [31:0] OFF_BPP       = 32'h08;
   localparam logic [31:0] OFF_STRIDE_HI = 32'h0A;
   localparam logic [31:0] OFF_STRIDE_LO = 32'h0B;
   localparam logic [31:0] OFF_VRAM_0    = 32'h0C;
   localparam logic [31:0] OFF_VRAM_1    = 32'h0D;
   localparam logic [31:0] OFF_VRAM_2    = 32'h0E;
   localparam logic [31:0] OFF_VRAM_3    = 32'h0F;
   localparam logic [31:0] OFF_SIZE_0    = 32'h10;
   localparam logic [31:0] OFF_SIZE_1    = 32'h11;
   localparam logic [31:0] OFF_SIZE_2    = 32'h12;
   localparam logic [31:0] OFF_SIZE_3    = 32'h13;
   localparam logic [31:0] OFF_ENABLE    = 32'h14;
   localparam logic [31:0] OFF_POINTER   = 32'h20;
   localparam logic [31:0] OFF_RED       = 32'h21;
   localparam logic [31:0] OFF_GREEN     = 32'h22;
   localparam logic [31:0] OFF_BLUE      = 32'h23;

   // Colour lanes, one-hot: red sits in the top byte of an entry
   localparam logic [2:0] LANE_RED   = 3'b100;
   localparam logic [2:0] LANE_GREEN = 3'b010;
   localparam logic [2:0] LANE_BLUE  = 3'b001;
   localparam logic [2:0] LANE_NONE  = 3'b000;

   typedef struct packed {
      logic [31:0] device_base;
      logic [31:0] magic_id;
      logic [15:0] screen_width;
      logic [15:0] screen_height;
      logic [5:0]  bits_per_pixel;
      logic [31:0] vram_base;
   } cfg_type;

   typedef struct packed {
      logic       enable_we;
      logic       pointer_we;
      logic [2:0] colour_lane;
      logic       advance;
   } wr_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STRIDE,
      ST_SIZE,
      ST_BYTE,
      ST_LOOKUP,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### rtl/fbpal_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Display register block channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbpal_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] bus_address;
   logic [1:0]  access_size;
   logic [31:0] write_data;
   logic [7:0]  lookup_index;

   modport source (
      output valid, req_type, bus_address, access_size, write_data, lookup_index,
      input  ready
   );
   modport sink (
      input  valid, req_type, bus_address, access_size, write_data, lookup_index,
      output ready
   );
endinterface

interface fbpal_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;

   modport source (
      output valid, read_data, red_out, green_out, blue_out,
      input  ready
   );
   modport sink (
      input  valid, read_data, red_out, green_out, blue_out,
      output ready
   );
endinterface
`default_nettype wire

### rtl/framebuffer_palette_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Display controller register block
// Bus register access, palette load through index/R/G/B registers and
// palette lookup, driven by a small sequencer around shared units.
// ----------------------------------------------------------------------------
// From request transfer to response valid: a bus read walks the stride and
// size states, then one byte register per cycle (1, 2 or 4 bytes); a bus
// write walks only the bytes; a palette lookup does one registered read.
// One request at a time: the next request transfers the cycle after the
// response transfer. Reads first run the shared multiplier twice (stride,
// then memory size). Reset is synchronous: configuration returns to its
// defaults and every palette entry reads as gray at once, with no sweep.
// ----------------------------------------------------------------------------
module framebuffer_palette_regs (
   input  logic        clock,
   input  logic        reset,
   fbpal_req_if.sink   req,
   fbpal_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fbpal_pkg::*;

   // Sequencer
   state_type state_ff;
   state_type state_in;

   logic accept;
   logic mul_stride;
   logic mul_size;
   logic byte_step;
   logic lookup_rd;

   // Configuration and architectural state
   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        enable_ff;
   logic        enable_in;
   logic [7:0]  pointer_ff;
   logic [7:0]  pointer_in;

   // Derived geometry
   logic [18:0] stride_ff;
   logic [18:0] stride_in;
   logic [31:0] size_ff;
   logic [31:0] size_in;

   // Request in flight
   logic [1:0]  type_ff;
   logic [1:0]  type_in;
   logic [31:0] off_ff;
   logic [31:0] off_in;
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;
   logic [1:0]  last_ff;
   logic [1:0]  last_in;
   logic [31:0] wdata_ff;
   logic [31:0] wdata_in;
   logic [31:0] rdata_ff;
   logic [31:0] rdata_in;
   logic [7:0]  idx_ff;
   logic [7:0]  idx_in;

   // Shared multiplier
   logic [18:0] mul_a;
   logic [15:0] mul_b;
   logic [34:0] mul_p;

   // Byte decoder
   logic [7:0]    rd_byte;
   wr_action_type action;
   logic          is_write;
   logic [7:0]    wr_byte;

   // Palette
   logic [7:0] pal_red;
   logic [7:0] pal_green;
   logic [7:0] pal_blue;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (req.req_type)
                  REQ_READ:   state_in = ST_STRIDE;
                  REQ_WRITE:  state_in = ST_BYTE;
                  REQ_LOOKUP: state_in = ST_LOOKUP;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_STRIDE: state_in = ST_SIZE;
         ST_SIZE:   state_in = ST_BYTE;
         ST_BYTE: begin
            if (cnt_ff == last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_LOOKUP: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs
   // ------------------------------------------------------------------
   always_comb begin
      req.ready  = 1'b0;
      rsp.valid  = 1'b0;
      mul_stride = 1'b0;
      mul_size   = 1'b0;
      byte_step  = 1'b0;
      lookup_rd  = 1'b0;
      case (state_ff)
         ST_IDLE:   req.ready  = 1'b1;
         ST_STRIDE: mul_stride = 1'b1;
         ST_SIZE:   mul_size   = 1'b1;
         ST_BYTE:   byte_step  = 1'b1;
         ST_LOOKUP: lookup_rd  = 1'b1;
         ST_DONE:   rsp.valid  = 1'b1;
         default:   req.ready  = 1'b0;
      endcase
   end

   assign accept = req.ready && req.valid;

   // ------------------------------------------------------------------
   // Shared multiplier: stride = width * bpp / 8, then size = stride * height
   // ------------------------------------------------------------------
   always_comb begin
      if (mul_size) begin
         mul_a = stride_ff;
         mul_b = cfg_ff.screen_height;
      end else begin
         mul_a = {3'b000, cfg_ff.screen_width};
         mul_b = {10'b0, cfg_ff.bits_per_pixel};
      end
   end

   assign mul_p = mul_a * mul_b;

   // ------------------------------------------------------------------
   // Byte register decoder, shared by every byte of an access
   // ------------------------------------------------------------------
   fbpal_byte_unit u_byte (
      .offset         (off_ff),
      .cfg            (cfg_ff),
      .stride         (stride_ff),
      .mem_size       (size_ff),
      .display_enable (enable_ff),
      .rd_byte        (rd_byte),
      .action         (action)
   );

   // The current write byte always sits in the top lane of wdata_ff
   assign wr_byte  = wdata_ff[31:24];
   assign is_write = byte_step && (type_ff == REQ_WRITE);

   fbpal_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (is_write && (action.colour_lane != LANE_NONE)),
      .wr_index (pointer_ff),
      .wr_lane  (action.colour_lane),
      .wr_data  (wr_byte),
      .rd_en    (lookup_rd),
      .rd_index (idx_ff),
      .red      (pal_red),
      .green    (pal_green),
      .blue     (pal_blue)
   );

   // ------------------------------------------------------------------
   // Next values
   // ------------------------------------------------------------------
   always_comb begin
      cfg_in     = cfg_ff;
      enable_in  = enable_ff;
      pointer_in = pointer_ff;
      stride_in  = stride_ff;
      size_in    = size_ff;
      type_in    = type_ff;
      off_in     = off_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      wdata_in   = wdata_ff;
      rdata_in   = rdata_ff;
      idx_in     = idx_ff;

      // Configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_BASE: cfg_in.device_base    = csr_wdata;
            CSR_MAGIC_ID:    cfg_in.magic_id       = csr_wdata;
            CSR_WIDTH:       cfg_in.screen_width   = csr_wdata[15:0];
            CSR_HEIGHT:      cfg_in.screen_height  = csr_wdata[15:0];
            CSR_BPP:         cfg_in.bits_per_pixel = csr_wdata[5:0];
            CSR_VRAM_BASE:   cfg_in.vram_base      = csr_wdata;
            default:         cfg_in                = cfg_ff;
         endcase
      end

      // Latch the request; bytes are walked as offset, offset+1, ...
      if (accept) begin
         type_in  = req.req_type;
         off_in   = req.bus_address - cfg_ff.device_base;
         cnt_in   = 2'd0;
         idx_in   = req.lookup_index;
         rdata_in = 32'h0;
         case (req.access_size)
            SIZE_BYTE: begin
               last_in  = 2'd0;
               wdata_in = req.write_data << 24;
            end
            SIZE_WORD: begin
               last_in  = 2'd1;
               wdata_in = req.write_data << 16;
            end
            default: begin
               last_in  = 2'd3;
               wdata_in = req.write_data;
            end
         endcase
      end

      if (mul_stride) begin
         stride_in = mul_p[21:3];
      end
      if (mul_size) begin
         size_in = mul_p[31:0];
      end

      // One byte register per cycle
      if (byte_step) begin
         off_in   = off_ff + 32'd1;
         cnt_in   = cnt_ff + 2'd1;
         wdata_in = wdata_ff << 8;
         if (type_ff == REQ_READ) begin
            rdata_in = {rdata_ff[23:0], rd_byte};
         end
      end

      if (is_write) begin
         if (action.enable_we) begin
            enable_in = wr_byte[0];
         end
         if (action.pointer_we) begin
            pointer_in = wr_byte;
         end else if (action.advance) begin
            pointer_in = pointer_ff + 8'd1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Control and configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         enable_ff  <= 1'b0;
         pointer_ff <= 8'h00;
         cfg_ff     <= '{device_base: 32'h0, magic_id: 32'h0,
                         screen_width: 16'd640, screen_height: 16'd480,
                         bits_per_pixel: 6'd8, vram_base: 32'h0};
      end else begin
         state_ff   <= state_in;
         enable_ff  <= enable_in;
         pointer_ff <= pointer_in;
         cfg_ff     <= cfg_in;
      end
   end

   // Datapath registers: no reset needed
   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
      size_ff   <= size_in;
      type_ff   <= type_in;
      off_ff    <= off_in;
      cnt_ff    <= cnt_in;
      last_ff   <= last_in;
      wdata_ff  <= wdata_in;
      rdata_ff  <= rdata_in;
      idx_ff    <= idx_in;
   end

   // ------------------------------------------------------------------
   // Response payload: held stable while waiting for the transfer
   // ------------------------------------------------------------------
   assign rsp.read_data = rdata_ff;
   assign rsp.red_out   = (type_ff == REQ_LOOKUP) ? pal_red   : 8'h00;
   assign rsp.green_out = (type_ff == REQ_LOOKUP) ? pal_green : 8'h00;
   assign rsp.blue_out  = (type_ff == REQ_LOOKUP) ? pal_blue  : 8'h00;

endmodule
`default_nettype wire

### rtl/fbpal_byte_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte register decoder
// Decodes one register byte offset into read data and a write action.
// ----------------------------------------------------------------------------
module fbpal_byte_unit (
   input  logic [31:0]                offset,
   input  fbpal_pkg::cfg_type         cfg,
   input  logic [18:0]                stride,
   input  logic [31:0]                mem_size,
   input  logic                       display_enable,
   output logic [7:0]                 rd_byte,
   output fbpal_pkg::wr_action_type   action
);
   import fbpal_pkg::*;

   always_comb begin
      case (offset)
         OFF_MAGIC_0:   rd_byte = cfg.magic_id[31:24];
         OFF_MAGIC_1:   rd_byte = cfg.magic_id[23:16];
         OFF_MAGIC_2:   rd_byte = cfg.magic_id[15:8];
         OFF_MAGIC_3:   rd_byte = cfg.magic_id[7:0];
         OFF_WIDTH_HI:  rd_byte = cfg.screen_width[15:8];
         OFF_WIDTH_LO:  rd_byte = cfg.screen_width[7:0];
         OFF_HEIGHT_HI: rd_byte = cfg.screen_height[15:8];
         OFF_HEIGHT_LO: rd_byte = cfg.screen_height[7:0];
         OFF_BPP:       rd_byte = {2'b00, cfg.bits_per_pixel};
         OFF_STRIDE_HI: rd_byte = stride[15:8];
         OFF_STRIDE_LO: rd_byte = stride[7:0];
         OFF_VRAM_0:    rd_byte = cfg.vram_base[31:24];
         OFF_VRAM_1:    rd_byte = cfg.vram_base[23:16];
         OFF_VRAM_2:    rd_byte = cfg.vram_base[15:8];
         OFF_VRAM_3:    rd_byte = cfg.vram_base[7:0];
         OFF_SIZE_0:    rd_byte = mem_size[31:24];
         OFF_SIZE_1:    rd_byte = mem_size[23:16];
         OFF_SIZE_2:    rd_byte = mem_size[15:8];
         OFF_SIZE_3:    rd_byte = mem_size[7:0];
         OFF_ENABLE:    rd_byte = {7'b0, display_enable};
         default:       rd_byte = 8'h00;
      endcase
   end

   always_comb begin
      action = '{enable_we: 1'b0, pointer_we: 1'b0, colour_lane: LANE_NONE,
                 advance: 1'b0};
      case (offset)
         OFF_ENABLE:  action.enable_we   = 1'b1;
         OFF_POINTER: action.pointer_we  = 1'b1;
         OFF_RED:     action.colour_lane = LANE_RED;
         OFF_GREEN:   action.colour_lane = LANE_GREEN;
         OFF_BLUE: begin
            action.colour_lane = LANE_BLUE;
            action.advance     = 1'b1;
         end
         default: action.advance = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

### rtl/fbpal_palette.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Colour palette store
// Palette memory with per-entry valid bits; unwritten entries read as gray.
// ----------------------------------------------------------------------------
module fbpal_palette (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [7:0]  wr_index,
   input  logic [2:0]  wr_lane,
   input  logic [7:0]  wr_data,
   input  logic        rd_en,
   input  logic [7:0]  rd_index,
   output logic [7:0]  red,
   output logic [7:0]  green,
   output logic [7:0]  blue
);
   import fbpal_pkg::*;

   logic [23:0]                mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [PALETTE_ENTRIES-1:0] valid_in;

   logic [PAL_AW-1:0] wr_addr;
   logic [PAL_AW-1:0] rd_addr;
   logic              wr_hit;
   logic              rd_hit;
   logic [2:0]        lane_we;
   logic [7:0]        gray_byte;

   logic [23:0]       rd_word_ff;
   logic              rd_valid_ff;
   logic              rd_hit_ff;
   logic [PAL_AW-1:0] rd_addr_ff;
   logic [7:0]        rd_gray;

   assign wr_addr   = wr_index[PAL_AW-1:0];
   assign rd_addr   = rd_index[PAL_AW-1:0];
   assign wr_hit    = ({1'b0, wr_index} < PAL_LIMIT);
   assign rd_hit    = ({1'b0, rd_index} < PAL_LIMIT);
   assign gray_byte = 8'(wr_addr);

   // An entry never written still holds its gray value: fill the other lanes
   assign lane_we = valid_ff[wr_addr] ? wr_lane : 3'b111;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en && wr_hit) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_hit) begin
         if (lane_we[2]) begin
            mem_ff[wr_addr][23:16] <= wr_lane[2] ? wr_data : gray_byte;
         end
         if (lane_we[1]) begin
            mem_ff[wr_addr][15:8] <= wr_lane[1] ? wr_data : gray_byte;
         end
         if (lane_we[0]) begin
            mem_ff[wr_addr][7:0] <= wr_lane[0] ? wr_data : gray_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_hit_ff   <= rd_hit;
         rd_addr_ff  <= rd_addr;
      end
   end

   assign rd_gray = 8'(rd_addr_ff);

   always_comb begin
      if (!rd_hit_ff) begin
         red   = 8'h00;
         green = 8'h00;
         blue  = 8'h00;
      end else if (rd_valid_ff) begin
         red   = rd_word_ff[23:16];
         green = rd_word_ff[15:8];
         blue  = rd_word_ff[7:0];
      end else begin
         red   = rd_gray;
         green = rd_gray;
         blue  = rd_gray;
      end
   end

endmodule
`default_nettype wire
